// ===== src/vector_to_angle_macros.svh =====
// Assertion helpers for the vector_to_angle block.
`ifndef VECTOR_TO_ANGLE_MACROS_SVH
`define VECTOR_TO_ANGLE_MACROS_SVH

// Check an implication at every rising clock edge outside reset.
`define V2A_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define V2A_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== src/v2a_pkg.sv =====
package v2a_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int COORD_BITS_DEF   = 16;
   localparam int GUARD_BITS       = 16;
   localparam int ANGLE_BITS       = 16;
   localparam int TABLE_LEN        = 24;
   localparam int STEP_IDX_W       = 5;

   // Signed Q16 radians carried through the rotation stages.
   localparam int ANG_W = 21;

   localparam logic signed [ANG_W-1:0] ANG_PI     = ANG_W'(205887);
   localparam logic signed [ANG_W-1:0] ANG_TWO_PI = ANG_W'(411775);

   // Q3.13 outputs for vectors on an axis, and the 2*pi wrap point and largest result.
   localparam logic [ANGLE_BITS-1:0] OUT_ZERO       = ANGLE_BITS'(0);
   localparam logic [ANGLE_BITS-1:0] OUT_PI         = ANGLE_BITS'(25736);
   localparam logic [ANGLE_BITS-1:0] OUT_HALF_PI    = ANGLE_BITS'(12868);
   localparam logic [ANGLE_BITS-1:0] OUT_3HALF_PI   = ANGLE_BITS'(38604);
   localparam logic [ANGLE_BITS+1:0] OUT_WRAP       = (ANGLE_BITS+2)'(51472);
   localparam logic [ANGLE_BITS-1:0] OUT_MAX        = ANGLE_BITS'(51471);

   typedef struct packed {
      logic                  valid;
      logic                  special;
      logic [ANGLE_BITS-1:0] spec_angle;
   } v2a_ctl_type;

   // atan(2^-i) in Q16, rounded to nearest.
   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         5'd0:    val = ANG_W'(51472);
         5'd1:    val = ANG_W'(30386);
         5'd2:    val = ANG_W'(16055);
         5'd3:    val = ANG_W'(8150);
         5'd4:    val = ANG_W'(4091);
         5'd5:    val = ANG_W'(2047);
         5'd6:    val = ANG_W'(1024);
         5'd7:    val = ANG_W'(512);
         5'd8:    val = ANG_W'(256);
         5'd9:    val = ANG_W'(128);
         5'd10:   val = ANG_W'(64);
         5'd11:   val = ANG_W'(32);
         5'd12:   val = ANG_W'(16);
         5'd13:   val = ANG_W'(8);
         5'd14:   val = ANG_W'(4);
         5'd15:   val = ANG_W'(2);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/v2a_prep.sv =====
module v2a_prep #(
   parameter int COORD_BITS = v2a_pkg::COORD_BITS_DEF,
   parameter int DATA_BITS  = COORD_BITS + v2a_pkg::GUARD_BITS + 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [COORD_BITS-1:0]          in_x,
   input  logic signed [COORD_BITS-1:0]          in_y,
   output v2a_pkg::v2a_ctl_type                  dst_ctl,
   output logic signed [DATA_BITS-1:0]           dst_x,
   output logic signed [DATA_BITS-1:0]           dst_y,
   output logic signed [v2a_pkg::ANG_W-1:0]      dst_z
);

   logic                                  valid_ff;
   v2a_pkg::v2a_ctl_type                  ctl_in;
   logic                                  special_ff;
   logic [v2a_pkg::ANGLE_BITS-1:0]        spec_angle_ff;
   logic signed [DATA_BITS-1:0]           x_ff, y_ff, x_in, y_in;
   logic signed [v2a_pkg::ANG_W-1:0]      z_ff, z_in;
   logic signed [DATA_BITS-1:0]           x_ext, y_ext;
   logic                                  x_neg;

   assign x_neg = in_x[COORD_BITS-1];
   assign x_ext = {{(DATA_BITS-COORD_BITS){in_x[COORD_BITS-1]}}, in_x};
   assign y_ext = {{(DATA_BITS-COORD_BITS){in_y[COORD_BITS-1]}}, in_y};

   // Fold into the right half plane and scale up by the guard bits.
   always_comb begin
      x_in = (x_neg ? -x_ext : x_ext) <<< v2a_pkg::GUARD_BITS;
      y_in = (x_neg ? -y_ext : y_ext) <<< v2a_pkg::GUARD_BITS;
      z_in = x_neg ? v2a_pkg::ANG_PI : '0;
      ctl_in.valid = in_valid;
      priority if (in_y == '0) begin
         ctl_in.special    = 1'b1;
         ctl_in.spec_angle = x_neg ? v2a_pkg::OUT_PI : v2a_pkg::OUT_ZERO;
      end else if (in_x == '0) begin
         ctl_in.special    = 1'b1;
         ctl_in.spec_angle = in_y[COORD_BITS-1] ? v2a_pkg::OUT_3HALF_PI
                                                : v2a_pkg::OUT_HALF_PI;
      end else begin
         ctl_in.special    = 1'b0;
         ctl_in.spec_angle = v2a_pkg::OUT_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      special_ff    <= ctl_in.special;
      spec_angle_ff <= ctl_in.spec_angle;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
   end

   assign dst_ctl = '{valid: valid_ff, special: special_ff, spec_angle: spec_angle_ff};
   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_z   = z_ff;

endmodule

// ===== src/v2a_stage.sv =====
module v2a_stage #(
   parameter int STEP      = 0,
   parameter int DATA_BITS = v2a_pkg::COORD_BITS_DEF + v2a_pkg::GUARD_BITS + 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  v2a_pkg::v2a_ctl_type                  src_ctl,
   input  logic signed [DATA_BITS-1:0]           src_x,
   input  logic signed [DATA_BITS-1:0]           src_y,
   input  logic signed [v2a_pkg::ANG_W-1:0]      src_z,
   output v2a_pkg::v2a_ctl_type                  dst_ctl,
   output logic signed [DATA_BITS-1:0]           dst_x,
   output logic signed [DATA_BITS-1:0]           dst_y,
   output logic signed [v2a_pkg::ANG_W-1:0]      dst_z
);

   localparam logic signed [v2a_pkg::ANG_W-1:0] ATAN_STEP =
      v2a_pkg::atan_q16(v2a_pkg::STEP_IDX_W'(STEP));

   logic                                  valid_ff;
   logic                                  special_ff;
   logic [v2a_pkg::ANGLE_BITS-1:0]        spec_angle_ff;
   logic signed [DATA_BITS-1:0]           x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [v2a_pkg::ANG_W-1:0]      z_ff, z_in;

   assign dx = src_y >>> STEP;
   assign dy = src_x >>> STEP;

   // Turn clockwise while y is non-negative, counterclockwise otherwise.
   always_comb begin
      if (!src_y[DATA_BITS-1]) begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ATAN_STEP;
      end else begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      special_ff    <= src_ctl.special;
      spec_angle_ff <= src_ctl.spec_angle;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
   end

   assign dst_ctl = '{valid: valid_ff, special: special_ff, spec_angle: spec_angle_ff};
   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_z   = z_ff;

endmodule

// ===== src/v2a_post.sv =====
module v2a_post (
   input  logic                                  clock,
   input  logic                                  reset,
   input  v2a_pkg::v2a_ctl_type                  src_ctl,
   input  logic signed [v2a_pkg::ANG_W-1:0]      src_z,
   output logic                                  out_valid,
   output logic [v2a_pkg::ANGLE_BITS-1:0]        out_angle
);

   localparam int A_W = v2a_pkg::ANG_W - 1;
   localparam int R_W = v2a_pkg::ANGLE_BITS + 2;

   logic                                  valid_a_ff, valid_b_ff;
   logic                                  special_a_ff;
   logic [v2a_pkg::ANGLE_BITS-1:0]        spec_angle_a_ff;
   logic [A_W-1:0]                        a_ff, a_in;
   logic signed [v2a_pkg::ANG_W-1:0]      z_fold;
   logic [A_W:0]                          a_round;
   logic [R_W-1:0]                        r_val;
   logic [v2a_pkg::ANGLE_BITS-1:0]        angle_ff, angle_in;

   // Stage A: fold negative angles up by 2*pi.
   assign z_fold = src_z[v2a_pkg::ANG_W-1] ? src_z + v2a_pkg::ANG_TWO_PI : src_z;
   assign a_in   = z_fold[A_W-1:0];

   // Stage B: round Q16 to Q3.13, wrap a rounded 2*pi to zero.
   assign a_round = {1'b0, a_ff} + (A_W+1)'(4);
   assign r_val   = a_round[A_W:3];

   always_comb begin
      if (special_a_ff) begin
         angle_in = spec_angle_a_ff;
      end else if (r_val >= v2a_pkg::OUT_WRAP) begin
         angle_in = v2a_pkg::OUT_ZERO;
      end else begin
         angle_in = r_val[v2a_pkg::ANGLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= src_ctl.valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      special_a_ff    <= src_ctl.special;
      spec_angle_a_ff <= src_ctl.spec_angle;
      a_ff            <= a_in;
      angle_ff        <= angle_in;
   end

   assign out_valid = valid_b_ff;
   assign out_angle = angle_ff;

endmodule

// ===== src/vector_to_angle.sv =====
// vector_to_angle: direction of a 2-D vector, atan2(y, x) folded into [0, 2*pi),
// as unsigned Q3.13 radians, computed by a pipelined CORDIC in vectoring mode.
//
// Request side: drive req_x_coord / req_y_coord and raise start; the item is
// taken at any rising edge with start high and busy low. busy is high only
// while reset is asserted, so outside reset a new item enters every cycle.
// Result side: rsp_valid pulses for one cycle with rsp_angle_rad. The receiver
// has no way to hold results off, and the pipeline never stalls.
//
// Pipeline from accept to rsp_valid: one fold stage, one register stage per
// micro-rotation, one stage to fold negative angles and one to round.
// Throughput is one item per cycle; the rotation chain, one stage per step,
// sets the latency.
// Vectors on an axis (and the zero vector) bypass the rotations: their angle
// rides alongside the data and replaces the CORDIC result at the end.
// Reset (synchronous) clears every stage valid bit; items in flight are dropped.
`include "vector_to_angle_macros.svh"

module vector_to_angle #(
   parameter int CORDIC_STEPS = v2a_pkg::CORDIC_STEPS_DEF,
   parameter int COORD_BITS   = v2a_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_BITS-1:0]          req_x_coord,
   input  logic signed [COORD_BITS-1:0]          req_y_coord,
   output logic                                  rsp_valid,
   output logic [v2a_pkg::ANGLE_BITS-1:0]        rsp_angle_rad
);

   // Headroom for the CORDIC gain and the fold of the most negative value.
   localparam int DATA_BITS = COORD_BITS + v2a_pkg::GUARD_BITS + 3;
   localparam int LATENCY   = CORDIC_STEPS + 3;

   v2a_pkg::v2a_ctl_type                  ctl_p [0:CORDIC_STEPS];
   logic signed [DATA_BITS-1:0]           x_p   [0:CORDIC_STEPS];
   logic signed [DATA_BITS-1:0]           y_p   [0:CORDIC_STEPS];
   logic signed [v2a_pkg::ANG_W-1:0]      z_p   [0:CORDIC_STEPS];
   logic                                  accept;

   // Hold off new items only while reset clears the pipeline.
   assign busy   = reset;
   assign accept = start && !busy;

   v2a_prep #(
      .COORD_BITS (COORD_BITS),
      .DATA_BITS  (DATA_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_x     (req_x_coord),
      .in_y     (req_y_coord),
      .dst_ctl  (ctl_p[0]),
      .dst_x    (x_p[0]),
      .dst_y    (y_p[0]),
      .dst_z    (z_p[0])
   );

   // One micro-rotation per register stage.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      v2a_stage #(
         .STEP      (i),
         .DATA_BITS (DATA_BITS)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .src_ctl (ctl_p[i]),
         .src_x   (x_p[i]),
         .src_y   (y_p[i]),
         .src_z   (z_p[i]),
         .dst_ctl (ctl_p[i+1]),
         .dst_x   (x_p[i+1]),
         .dst_y   (y_p[i+1]),
         .dst_z   (z_p[i+1])
      );
   end

   v2a_post u_post (
      .clock     (clock),
      .reset     (reset),
      .src_ctl   (ctl_p[CORDIC_STEPS]),
      .src_z     (z_p[CORDIC_STEPS]),
      .out_valid (rsp_valid),
      .out_angle (rsp_angle_rad)
   );

   // A result always stays below 2*pi.
   `V2A_ASSERT_NEVER(a_angle_range, rsp_valid && (rsp_angle_rad > v2a_pkg::OUT_MAX), "angle out of range")

   // Every result traces back to an accepted item.
   `V2A_ASSERT_IMPL(a_result_origin, rsp_valid, $past(accept, LATENCY), "result without item")

   // A vector on the positive x axis comes out as angle zero.
   `V2A_ASSERT_IMPL(a_pos_x_axis, rsp_valid && $past((req_y_coord == '0) && !req_x_coord[COORD_BITS-1], LATENCY), rsp_angle_rad == v2a_pkg::OUT_ZERO, "positive x axis not zero")

endmodule
